// File: rtl/core/ssp_pkg.sv
// Shared types and constants for the spindle speed PWM controller.
package ssp_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_RPM_MIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RPM_MAX      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OVERRIDE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LASER_MODE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_GRADIENT = 3'd4;

	localparam logic       OP_SET_STATE = 1'b0;
	localparam logic       OP_POLL      = 1'b1;

	localparam logic [1:0] CMD_OFF     = 2'd0;
	localparam logic [1:0] CMD_CW      = 2'd1;
	localparam logic [1:0] CMD_CCW     = 2'd2;
	localparam logic [1:0] CMD_CCW_ALT = 2'd3;

	localparam logic [15:0] RPM_MIN_RST      = 16'd0;
	localparam logic [15:0] RPM_MAX_RST      = 16'd1000;
	localparam logic [7:0]  OVERRIDE_RST     = 8'd100;
	localparam logic [23:0] PWM_GRADIENT_RST = 24'd65536;

	localparam logic [15:0] PWM_MAX_LEVEL_DEF = 16'd1023;
	localparam logic [15:0] PWM_MIN_LEVEL_DEF = 16'd1;
	localparam logic [15:0] PWM_OFF_LEVEL_DEF = 16'd0;

	// rpm * pct * 256 / 100 == (rpm * pct * 64) / 25
	localparam logic [31:0] DIVISOR   = 32'd25;
	// floor(2^32 / 25); quotient from it is at most one low
	localparam logic [31:0] RECIP_25  = 32'd171798691;

	localparam logic [7:0] CCW_FLAG = 8'h80;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] tx_byte;
		logic       sel;
	} spi_res_t;

endpackage

// File: rtl/core/ssp_mul.sv
// Shared 32x32 multiplier with registered product.
module ssp_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] prod
);

	logic [63:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

// File: rtl/core/ssp_spi.sv
// Three-phase SPI speed sender: low byte, high byte, select release.
module ssp_spi (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             poll,
	input  logic [15:0]      speed,
	input  logic             ccw,
	input  logic             spi_idle,
	output ssp_pkg::spi_res_t res
);

	typedef enum logic [2:0] {
		PH_START   = 3'b001,
		PH_HIGH    = 3'b010,
		PH_RELEASE = 3'b100
	} phase_t;

	phase_t     phase_q, phase_nxt;
	logic [7:0] hold_q, hold_nxt;
	logic       sel_q, sel_nxt;
	logic       bv;
	logic [7:0] bdata;

	always_comb begin
		phase_nxt = phase_q;
		hold_nxt  = hold_q;
		sel_nxt   = sel_q;
		bv        = 1'b0;
		bdata     = 8'd0;
		case (phase_q)
			PH_START: begin
				hold_nxt  = ccw ? (speed[15:8] | ssp_pkg::CCW_FLAG) : speed[15:8];
				sel_nxt   = 1'b0;
				bv        = 1'b1;
				bdata     = speed[7:0];
				phase_nxt = PH_HIGH;
			end
			PH_HIGH: begin
				if (spi_idle) begin
					bv        = 1'b1;
					bdata     = hold_q;
					phase_nxt = PH_RELEASE;
				end
			end
			default: begin
				if (spi_idle) begin
					sel_nxt   = 1'b1;
					phase_nxt = PH_START;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			hold_q  <= 8'd0;
			sel_q   <= 1'b1;
		end else if (poll) begin
			phase_q <= phase_nxt;
			hold_q  <= hold_nxt;
			sel_q   <= sel_nxt;
		end
	end

	assign res.byte_valid = bv;
	assign res.tx_byte    = bdata;
	assign res.sel        = sel_q;

endmodule

// File: rtl/core/spindle_speed_pwm_controller.sv
// Spindle speed PWM controller top level: sequencer, state and config registers.
// A set-state item that changes speed goes from acceptance through four passes
// through the one shared 32x32 multiplier (rpm * override, divide by 25 via
// reciprocal, quotient check, PWM gradient), a remainder fix-up state and a
// write-back state. Poll, disable and ignored items go straight from acceptance
// to write-back. in_ready is high only while the sequencer is idle, so a new item
// is taken in the cycle after the previous write-back at the earliest; the result waits in
// the output register until taken, and the next item is accepted meanwhile, its
// write-back held until then. Config writes are always accepted.
module spindle_speed_pwm_controller #(
	parameter logic [15:0] PWM_MAX_LEVEL = ssp_pkg::PWM_MAX_LEVEL_DEF,
	parameter logic [15:0] PWM_MIN_LEVEL = ssp_pkg::PWM_MIN_LEVEL_DEF,
	parameter logic [15:0] PWM_OFF_LEVEL = ssp_pkg::PWM_OFF_LEVEL_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           operation,
	input  logic [1:0]                     spindle_cmd,
	input  logic [15:0]                    rpm,
	input  logic                           abort_active,
	input  logic                           check_mode,
	input  logic                           spi_idle,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [15:0]                    pwm_level,
	output logic                           pwm_on,
	output logic                           enable_pin,
	output logic                           direction_pin,
	output logic [15:0]                    actual_speed,
	output logic                           spi_byte_valid,
	output logic [7:0]                     spi_byte,
	output logic                           chip_select
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL1 = 7'b0000010,
		ST_MUL2 = 7'b0000100,
		ST_MUL3 = 7'b0001000,
		ST_FIX  = 7'b0010000,
		ST_MUL4 = 7'b0100000,
		ST_WB   = 7'b1000000
	} state_t;

	state_t state_q, state_nxt;

	// config
	logic [15:0] rpm_min_q, rpm_max_q;
	logic [7:0]  ovr_q;
	logic        laser_q;
	logic [23:0] grad_q;

	// latched item
	logic        op_q, ccw_q, off_q, ignore_q, idle_q;
	logic [15:0] rpm_q;

	// datapath
	logic [29:0] x_q;
	logic [25:0] q0_q;
	logic [25:0] scaled_q;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;

	// block state
	logic [15:0] pwm_q;
	logic        pwm_en_q, enable_q, dir_q, last_ccw_q;
	logic [23:0] speed_q;
	logic        obv_q;
	logic [7:0]  obyte_q;
	logic        out_valid_q;

	logic        accept, commit, speed_path, cmd_ccw;
	logic [29:0] rem;
	logic [25:0] diff;
	logic [25:0] min_ext, max_ext;
	logic [24:0] lin;
	logic [15:0] lin_sat;
	logic [15:0] pwm_nxt;
	logic [23:0] speed_nxt;
	ssp_pkg::spi_res_t spi_res;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign cmd_ccw   = (spindle_cmd != ssp_pkg::CMD_CW);
	assign commit    = (state_q == ST_WB) && (!out_valid_q || out_ready);
	assign speed_path = !op_q && !ignore_q && !off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpm_min_q <= ssp_pkg::RPM_MIN_RST;
			rpm_max_q <= ssp_pkg::RPM_MAX_RST;
			ovr_q     <= ssp_pkg::OVERRIDE_RST;
			laser_q   <= 1'b0;
			grad_q    <= ssp_pkg::PWM_GRADIENT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				ssp_pkg::REG_RPM_MIN:      rpm_min_q <= cfg_data[15:0];
				ssp_pkg::REG_RPM_MAX:      rpm_max_q <= cfg_data[15:0];
				ssp_pkg::REG_OVERRIDE:     ovr_q     <= cfg_data[7:0];
				ssp_pkg::REG_LASER_MODE:   laser_q   <= cfg_data[0];
				ssp_pkg::REG_PWM_GRADIENT: grad_q    <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (operation == ssp_pkg::OP_SET_STATE && !abort_active && !check_mode
						&& spindle_cmd != ssp_pkg::CMD_OFF)
						state_nxt = ST_MUL1;
					else
						state_nxt = ST_WB;
				end
			end
			ST_MUL1: state_nxt = ST_MUL2;
			ST_MUL2: state_nxt = ST_MUL3;
			ST_MUL3: state_nxt = ST_FIX;
			ST_FIX:  state_nxt = ST_MUL4;
			ST_MUL4: state_nxt = ST_WB;
			ST_WB:   if (commit) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= (operation == ssp_pkg::OP_POLL);
			ccw_q    <= cmd_ccw;
			off_q    <= (spindle_cmd == ssp_pkg::CMD_OFF);
			ignore_q <= abort_active || check_mode;
			idle_q   <= spi_idle;
			rpm_q    <= (laser_q && cmd_ccw) ? 16'd0 : rpm;
		end
	end

	// operand select for the shared multiplier; gradient operands stay on
	// through write-back so the product holds while the result waits
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (state_q)
			ST_MUL1: begin
				mul_a = {16'd0, rpm_q};
				mul_b = {24'd0, ovr_q};
			end
			ST_MUL2: begin
				mul_a = {2'd0, prod[23:0], 6'd0};
				mul_b = ssp_pkg::RECIP_25;
			end
			ST_MUL3: begin
				mul_a = {6'd0, prod[57:32]};
				mul_b = ssp_pkg::DIVISOR;
			end
			ST_MUL4, ST_WB: begin
				mul_a = {8'd0, diff[23:0]};
				mul_b = {8'd0, grad_q};
			end
			default: ;
		endcase
	end

	ssp_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign min_ext = {2'd0, rpm_min_q, 8'd0};
	assign max_ext = {2'd0, rpm_max_q, 8'd0};
	assign rem     = x_q - prod[29:0];
	assign diff    = scaled_q - min_ext;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_MUL2: x_q      <= {prod[23:0], 6'd0};
			ST_MUL3: q0_q     <= prod[57:32];
			ST_FIX:  scaled_q <= q0_q + ((rem >= ssp_pkg::DIVISOR[29:0]) ? 26'd1 : 26'd0);
			default: ;
		endcase
	end

	assign lin     = {1'b0, prod[47:24]} + {9'd0, PWM_MIN_LEVEL};
	assign lin_sat = (lin[24:16] != 9'd0) ? 16'hFFFF : lin[15:0];

	always_comb begin
		if (rpm_min_q >= rpm_max_q || scaled_q >= max_ext) begin
			speed_nxt = max_ext[23:0];
			pwm_nxt   = PWM_MAX_LEVEL;
		end else if (scaled_q <= min_ext) begin
			if (scaled_q == 26'd0) begin
				speed_nxt = 24'd0;
				pwm_nxt   = PWM_OFF_LEVEL;
			end else begin
				speed_nxt = min_ext[23:0];
				pwm_nxt   = PWM_MIN_LEVEL;
			end
		end else begin
			speed_nxt = scaled_q[23:0];
			pwm_nxt   = lin_sat;
		end
	end

	ssp_spi u_spi (
		.clk      (clk),
		.arst_n   (arst_n),
		.poll     (commit && op_q),
		.speed    (speed_q[23:8]),
		.ccw      (last_ccw_q),
		.spi_idle (idle_q),
		.res      (spi_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_q      <= 16'd0;
			pwm_en_q   <= 1'b0;
			enable_q   <= 1'b0;
			dir_q      <= 1'b0;
			speed_q    <= 24'd0;
			last_ccw_q <= 1'b0;
		end else if (commit && !op_q && !ignore_q) begin
			if (off_q) begin
				speed_q  <= 24'd0;
				pwm_en_q <= 1'b0;
				enable_q <= 1'b0;
			end else if (speed_path) begin
				last_ccw_q <= ccw_q;
				dir_q      <= ccw_q;
				speed_q    <= speed_nxt;
				pwm_q      <= pwm_nxt;
				pwm_en_q   <= (pwm_nxt != PWM_OFF_LEVEL);
				enable_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			obv_q   <= op_q && spi_res.byte_valid;
			obyte_q <= op_q ? spi_res.tx_byte : 8'd0;
		end
	end

	assign out_valid      = out_valid_q;
	assign pwm_level      = pwm_q;
	assign pwm_on         = pwm_en_q;
	assign enable_pin     = enable_q;
	assign direction_pin  = dir_q;
	assign actual_speed   = speed_q[23:8];
	assign spi_byte_valid = obv_q;
	assign spi_byte       = obyte_q;
	assign chip_select    = spi_res.sel;

endmodule

// File: tb/sv/tb_spindle_speed_pwm_controller.sv
`timescale 1ns / 1ps
// Self-checking testbench for the spindle speed PWM controller with its SPI speed reporter.
module tb_spindle_speed_pwm_controller;

	localparam logic [1:0] SEND_LOW     = 2'd0;
	localparam logic [1:0] SEND_HIGH    = 2'd1;
	localparam logic [1:0] SEND_RELEASE = 2'd2;

	localparam int PHASES          = 9;
	localparam int ITEMS_PER_PHASE = 125;

	typedef struct packed {
		logic        operation;
		logic [1:0]  spindle_cmd;
		logic [15:0] rpm;
		logic        abort_active;
		logic        check_mode;
		logic        spi_idle;
	} spindle_item_t;

	typedef struct packed {
		logic [15:0] pwm_level;
		logic        pwm_on;
		logic        enable_pin;
		logic        direction_pin;
		logic [15:0] actual_speed;
		logic        spi_byte_valid;
		logic [7:0]  spi_byte;
		logic        chip_select;
	} spindle_status_t;

	class spindle_tracker;
		logic [15:0] rpm_lo;
		logic [15:0] rpm_hi;
		logic [7:0]  ovr_pct;
		logic        laser;
		logic [23:0] grad;

		logic [15:0] compare;
		logic        pwm_run;
		logic        en;
		logic        dir;
		logic [23:0] speed_q8;
		logic        ccw_last;
		logic [1:0]  phase;
		logic [7:0]  hi_hold;
		logic        cs;

		spindle_status_t status_due[$];
		int mismatch_count;
		int checked_count;

		function new();
			rpm_lo = ssp_pkg::RPM_MIN_RST;
			rpm_hi = ssp_pkg::RPM_MAX_RST;
			ovr_pct = ssp_pkg::OVERRIDE_RST;
			laser = 1'b0;
			grad = ssp_pkg::PWM_GRADIENT_RST;
			compare = '0;
			pwm_run = 1'b0;
			en = 1'b0;
			dir = 1'b0;
			speed_q8 = '0;
			ccw_last = 1'b0;
			phase = SEND_LOW;
			hi_hold = '0;
			cs = 1'b1;
			mismatch_count = 0;
			checked_count = 0;
		endfunction

		function void set_reg(logic [ssp_pkg::CFG_IDX_W-1:0] idx,
			logic [ssp_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				ssp_pkg::REG_RPM_MIN:      rpm_lo = data[15:0];
				ssp_pkg::REG_RPM_MAX:      rpm_hi = data[15:0];
				ssp_pkg::REG_OVERRIDE:     ovr_pct = data[7:0];
				ssp_pkg::REG_LASER_MODE:   laser = data[0];
				ssp_pkg::REG_PWM_GRADIENT: grad = data;
				default: ;
			endcase
		endfunction

		// scaled rpm is Q16.8, gradient Q8.16, so the product is shifted down by 24
		function void set_speed(logic [15:0] r);
			longint unsigned scaled;
			longint unsigned lo_q;
			longint unsigned hi_q;
			longint unsigned lin;
			logic [15:0] level;
			scaled = 64'(r) * 64'(ovr_pct);
			scaled = (scaled << 8) / 100;
			lo_q = 64'(rpm_lo) << 8;
			hi_q = 64'(rpm_hi) << 8;
			if (rpm_lo >= rpm_hi || scaled >= hi_q) begin
				speed_q8 = hi_q[23:0];
				level = ssp_pkg::PWM_MAX_LEVEL_DEF;
			end else if (scaled <= lo_q) begin
				if (scaled == 0) begin
					speed_q8 = '0;
					level = ssp_pkg::PWM_OFF_LEVEL_DEF;
				end else begin
					speed_q8 = lo_q[23:0];
					level = ssp_pkg::PWM_MIN_LEVEL_DEF;
				end
			end else begin
				lin = (((scaled - lo_q) * 64'(grad)) >> 24)
					+ 64'(ssp_pkg::PWM_MIN_LEVEL_DEF);
				speed_q8 = scaled[23:0];
				level = (lin > 64'hFFFF) ? 16'hFFFF : lin[15:0];
			end
			compare = level;
			pwm_run = (level != ssp_pkg::PWM_OFF_LEVEL_DEF);
			en = 1'b1;
		endfunction

		function void note_item(spindle_item_t it);
			spindle_status_t s;
			logic [15:0] spd;
			s = '0;
			if (it.operation == ssp_pkg::OP_SET_STATE) begin
				if (!it.abort_active && !it.check_mode) begin
					if (it.spindle_cmd == ssp_pkg::CMD_OFF) begin
						speed_q8 = '0;
						pwm_run = 1'b0;
						en = 1'b0;
					end else begin
						ccw_last = (it.spindle_cmd != ssp_pkg::CMD_CW);
						dir = ccw_last;
						set_speed((laser && ccw_last) ? 16'd0 : it.rpm);
					end
				end
			end else if (phase == SEND_LOW) begin
				// a new frame starts whether or not the SPI is still shifting
				spd = speed_q8[23:8];
				hi_hold = spd[15:8];
				if (ccw_last)
					hi_hold = hi_hold | ssp_pkg::CCW_FLAG;
				cs = 1'b0;
				s.spi_byte_valid = 1'b1;
				s.spi_byte = spd[7:0];
				phase = SEND_HIGH;
			end else if (it.spi_idle) begin
				if (phase == SEND_HIGH) begin
					s.spi_byte_valid = 1'b1;
					s.spi_byte = hi_hold;
					phase = SEND_RELEASE;
				end else begin
					cs = 1'b1;
					phase = SEND_LOW;
				end
			end
			s.pwm_level = compare;
			s.pwm_on = pwm_run;
			s.enable_pin = en;
			s.direction_pin = dir;
			s.actual_speed = speed_q8[23:8];
			s.chip_select = cs;
			status_due.push_back(s);
		endfunction

		task report(string field, logic [31:0] got_v, logic [31:0] exp_v);
			mismatch_count++;
			$display("MISMATCH at result %0d: %s got %0h, predicted %0h",
				checked_count, field, got_v, exp_v);
		endtask

		task check_status(spindle_status_t got);
			spindle_status_t want;
			if (status_due.size() == 0) begin
				report("result with no item outstanding", 32'(got.pwm_level), 32'd0);
				return;
			end
			want = status_due.pop_front();
			if (got.pwm_level !== want.pwm_level)
				report("pwm_level", 32'(got.pwm_level), 32'(want.pwm_level));
			if (got.pwm_on !== want.pwm_on)
				report("pwm_on", 32'(got.pwm_on), 32'(want.pwm_on));
			if (got.enable_pin !== want.enable_pin)
				report("enable_pin", 32'(got.enable_pin), 32'(want.enable_pin));
			if (got.direction_pin !== want.direction_pin)
				report("direction_pin", 32'(got.direction_pin), 32'(want.direction_pin));
			if (got.actual_speed !== want.actual_speed)
				report("actual_speed", 32'(got.actual_speed), 32'(want.actual_speed));
			if (got.spi_byte_valid !== want.spi_byte_valid)
				report("spi_byte_valid", 32'(got.spi_byte_valid), 32'(want.spi_byte_valid));
			if (got.spi_byte !== want.spi_byte)
				report("spi_byte", 32'(got.spi_byte), 32'(want.spi_byte));
			if (got.chip_select !== want.chip_select)
				report("chip_select", 32'(got.chip_select), 32'(want.chip_select));
			checked_count++;
		endtask
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [ssp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic                           operation = 1'b0;
	logic [1:0]                     spindle_cmd = '0;
	logic [15:0]                    rpm = '0;
	logic                           abort_active = 1'b0;
	logic                           check_mode = 1'b0;
	logic                           spi_idle = 1'b0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [15:0]                    pwm_level;
	logic                           pwm_on;
	logic                           enable_pin;
	logic                           direction_pin;
	logic [15:0]                    actual_speed;
	logic                           spi_byte_valid;
	logic [7:0]                     spi_byte;
	logic                           chip_select;

	spindle_tracker  sb;
	spindle_status_t seen;
	bit              idle_on = 1'b1;
	int              stall_left = 0;
	int              n_set = 0;
	int              n_poll = 0;
	int              n_cfg = 0;
	int              n_settings = 0;

	assign seen = {pwm_level, pwm_on, enable_pin, direction_pin, actual_speed,
		spi_byte_valid, spi_byte, chip_select};

	spindle_speed_pwm_controller dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.spindle_cmd   (spindle_cmd),
		.rpm           (rpm),
		.abort_active  (abort_active),
		.check_mode    (check_mode),
		.spi_idle      (spi_idle),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pwm_level     (pwm_level),
		.pwm_on        (pwm_on),
		.enable_pin    (enable_pin),
		.direction_pin (direction_pin),
		.actual_speed  (actual_speed),
		.spi_byte_valid(spi_byte_valid),
		.spi_byte      (spi_byte),
		.chip_select   (chip_select)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side: check each taken item, start random out_ready stalls while idle_on is set
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_status(seen);
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (arst_n && idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 4);
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n;
		end
	end

	function automatic logic [23:0] fit_gradient(logic [15:0] lo, logic [15:0] hi);
		longint unsigned g;
		if (hi <= lo)
			return 24'hFFFFFF;
		g = (64'(ssp_pkg::PWM_MAX_LEVEL_DEF - ssp_pkg::PWM_MIN_LEVEL_DEF) << 16)
			/ 64'(hi - lo);
		return (g > 64'hFFFFFF) ? 24'hFFFFFF : g[23:0];
	endfunction

	// mostly rpm values that scale to no more than just past the top of the current window
	function automatic logic [15:0] pick_rpm();
		int unsigned bound;
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1, 2: return 16'($urandom_range(0, 65535));
			default: begin
				if (sb.ovr_pct == 0)
					bound = 65535;
				else
					bound = (32'(sb.rpm_hi) * 100) / sb.ovr_pct + 2;
				if (bound > 65535)
					bound = 65535;
				return 16'($urandom_range(0, bound));
			end
		endcase
	endfunction

	function automatic spindle_item_t rand_item();
		spindle_item_t it;
		int unsigned c;
		it.operation = ($urandom_range(0, 9) < 4) ? ssp_pkg::OP_POLL : ssp_pkg::OP_SET_STATE;
		c = $urandom_range(0, 15);
		if (c < 2)
			it.spindle_cmd = ssp_pkg::CMD_OFF;
		else if (c < 9)
			it.spindle_cmd = ssp_pkg::CMD_CW;
		else if (c < 15)
			it.spindle_cmd = ssp_pkg::CMD_CCW;
		else
			it.spindle_cmd = ssp_pkg::CMD_CCW_ALT;
		it.rpm = pick_rpm();
		it.abort_active = ($urandom_range(0, 15) == 0);
		it.check_mode = ($urandom_range(0, 15) == 0);
		it.spi_idle = ($urandom_range(0, 2) != 0);
		return it;
	endfunction

	task automatic send_item(spindle_item_t it);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= it.operation;
		spindle_cmd <= it.spindle_cmd;
		rpm <= it.rpm;
		abort_active <= it.abort_active;
		check_mode <= it.check_mode;
		spi_idle <= it.spi_idle;
		do @(posedge clk); while (!in_ready);
		sb.note_item(it);
		if (it.operation == ssp_pkg::OP_POLL)
			n_poll++;
		else
			n_set++;
	endtask

	task automatic send_fields(logic op, logic [1:0] cmd, logic [15:0] r, logic ab,
		logic chk, logic idle);
		spindle_item_t it;
		it = '{operation: op, spindle_cmd: cmd, rpm: r, abort_active: ab,
			check_mode: chk, spi_idle: idle};
		send_item(it);
	endtask

	// hold the sender until every outstanding result has been taken
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.status_due.size() != 0);
	endtask

	task automatic reconfigure(logic [15:0] lo, logic [15:0] hi, logic [7:0] pct,
		logic las, logic [23:0] grad);
		logic [ssp_pkg::CFG_DATA_W-1:0] vals [5];
		logic [ssp_pkg::CFG_IDX_W-1:0]  idxs [5];
		drain();
		idxs = '{ssp_pkg::REG_RPM_MIN, ssp_pkg::REG_RPM_MAX, ssp_pkg::REG_OVERRIDE,
			ssp_pkg::REG_LASER_MODE, ssp_pkg::REG_PWM_GRADIENT};
		vals = '{24'(lo), 24'(hi), 24'(pct), 24'(las), grad};
		for (int k = 0; k < 5; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idxs[k];
			cfg_data <= vals[k];
			do @(posedge clk); while (!cfg_ready);
			sb.set_reg(idxs[k], vals[k]);
			n_cfg++;
		end
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	task automatic config_random();
		logic [15:0] lo;
		int unsigned hi;
		logic [7:0] pct;
		logic las;
		logic [23:0] grad;
		lo = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 2000));
		hi = 32'(lo) + $urandom_range(1, 30000);
		pct = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
			8'($urandom_range(10, 200));
		las = 1'($urandom_range(0, 1));
		grad = $urandom_range(0, 1) ? fit_gradient(lo, 16'(hi)) :
			24'($urandom_range(0, 24'hFFFFFF));
		reconfigure(lo, 16'(hi), pct, las, grad);
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// SPI frame from reset: busy polls stall only the later phases
		send_fields(ssp_pkg::OP_POLL, ssp_pkg::CMD_OFF, 16'hFFFF, 1'b1, 1'b1, 1'b0);
		send_fields(ssp_pkg::OP_POLL, ssp_pkg::CMD_CW, 16'h0000, 1'b0, 1'b0, 1'b0);
		send_fields(ssp_pkg::OP_POLL, ssp_pkg::CMD_CW, 16'h0000, 1'b0, 1'b0, 1'b1);
		send_fields(ssp_pkg::OP_POLL, ssp_pkg::CMD_CW, 16'h0000, 1'b0, 1'b0, 1'b1);
		send_fields(ssp_pkg::OP_SET_STATE, ssp_pkg::CMD_CW, 16'd0, 1'b0, 1'b0, 1'b0);
		send_fields(ssp_pkg::OP_SET_STATE, ssp_pkg::CMD_CW, 16'd500, 1'b0, 1'b0, 1'b0);
		send_fields(ssp_pkg::OP_SET_STATE, ssp_pkg::CMD_CCW, 16'hFFFF, 1'b0, 1'b0, 1'b1);
		send_fields(ssp_pkg::OP_SET_STATE, ssp_pkg::CMD_CCW_ALT, 16'd300, 1'b0, 1'b0, 1'b0);
		send_fields(ssp_pkg::OP_SET_STATE, ssp_pkg::CMD_CW, 16'd700, 1'b1, 1'b0, 1'b0);
		send_fields(ssp_pkg::OP_SET_STATE, ssp_pkg::CMD_OFF, 16'd700, 1'b0, 1'b1, 1'b0);
		// frame with the direction flag in the high byte
		send_fields(ssp_pkg::OP_POLL, ssp_pkg::CMD_CW, 16'd0, 1'b0, 1'b0, 1'b1);
		send_fields(ssp_pkg::OP_POLL, ssp_pkg::CMD_CW, 16'd0, 1'b0, 1'b0, 1'b1);
		send_fields(ssp_pkg::OP_POLL, ssp_pkg::CMD_CW, 16'd0, 1'b0, 1'b0, 1'b1);
		send_fields(ssp_pkg::OP_SET_STATE, ssp_pkg::CMD_OFF, 16'd1234, 1'b0, 1'b0, 1'b0);
		send_fields(ssp_pkg::OP_POLL, ssp_pkg::CMD_CW, 16'd0, 1'b0, 1'b0, 1'b0);
		send_fields(ssp_pkg::OP_POLL, ssp_pkg::CMD_CW, 16'd0, 1'b0, 1'b0, 1'b1);

		reconfigure(16'd100, 16'd2000, 8'd200, 1'b1, 24'hFFFFFF);
		send_fields(ssp_pkg::OP_SET_STATE, ssp_pkg::CMD_CW, 16'd999, 1'b0, 1'b0, 1'b0);
		send_fields(ssp_pkg::OP_SET_STATE, ssp_pkg::CMD_CCW, 16'd1500, 1'b0, 1'b0, 1'b0);
		send_fields(ssp_pkg::OP_SET_STATE, ssp_pkg::CMD_CW, 16'd10, 1'b0, 1'b0, 1'b0);
		send_fields(ssp_pkg::OP_SET_STATE, ssp_pkg::CMD_CW, 16'hFFFF, 1'b0, 1'b0, 1'b0);
		// empty window: even S0 goes to the top level
		reconfigure(16'd500, 16'd500, 8'd255, 1'b0, 24'd0);
		send_fields(ssp_pkg::OP_SET_STATE, ssp_pkg::CMD_CW, 16'd0, 1'b0, 1'b0, 1'b0);
		reconfigure(16'd0, 16'hFFFF, 8'd0, 1'b0, 24'd0);
		send_fields(ssp_pkg::OP_SET_STATE, ssp_pkg::CMD_CW, 16'hFFFF, 1'b0, 1'b0, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: reconfigure(ssp_pkg::RPM_MIN_RST, ssp_pkg::RPM_MAX_RST,
					ssp_pkg::OVERRIDE_RST, 1'b0, ssp_pkg::PWM_GRADIENT_RST);
				1: reconfigure(16'd0, 16'hFFFF, 8'd200, 1'b1, 24'hFFFFFF);
				2: reconfigure(16'hFFFF, 16'd0, 8'd10, 1'b0, 24'd0);
				3: reconfigure(16'd100, 16'd3000, 8'd10, 1'b0, fit_gradient(16'd100, 16'd3000));
				default: config_random();
			endcase
			idle_on = (p != PHASES - 1);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				send_item(rand_item());
				if ($urandom_range(0, 99) == 0)
					drain();
			end
		end

		drain();
		repeat (12) @(posedge clk);
		$display("Run covered %0d set-state and %0d poll items,", n_set, n_poll);
		$display("%0d register writes in %0d settings, %0d results compared field by field.",
			n_cfg, n_settings, sb.checked_count);
		if (sb.mismatch_count == 0 && sb.status_due.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
